// ===== rtl/core/rsp_pkg.sv =====
// shared types and constants for the ray sphere pick nearest core
`default_nettype none
package rsp_pkg;

    localparam int KEEP_NEAREST_DEF = 8;
    localparam int TAG_BITS_DEF     = 16;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int REPORT_MAX       = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int WORD_W           = 32;
    localparam int DIR_W            = 18;
    localparam int NUM_WORDS        = 16;

    localparam logic [3:0] RADIUS_IDX = 4'd15;
    localparam logic [3:0] CENTER_IDX = 4'd12;
    localparam logic [3:0] TRANS_IDX  = 4'd9;
    localparam logic [30:0] U31_MAX   = 31'h7fffffff;
    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 18'sd65536;

    typedef enum logic [2:0] {
        CFG_EYE_X = 3'd0,
        CFG_EYE_Y = 3'd1,
        CFG_EYE_Z = 3'd2,
        CFG_DIR_X = 3'd3,
        CFG_DIR_Y = 3'd4,
        CFG_DIR_Z = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_SQ1,
        S_SQ1W,
        S_RAD,
        S_RSAT,
        S_RSQ,
        S_TEST,
        S_SQ2W,
        S_INS,
        S_SUM,
        S_HITS
    } t_state;

    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        logic [15:0]                      tag;
        logic                             eval;
        logic                             report;
    } t_job;

endpackage
`default_nettype wire

// ===== rtl/core/rsp_front.sv =====
// front end: record word store and job classification
`default_nettype none
module rsp_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_full,
    input  wire logic signed [31:0]          i_word_value,
    input  wire logic [3:0]                  i_word_index,
    input  wire logic [15:0]                 i_instance_tag,
    input  wire logic                        i_frame_end,
    output logic                             o_push,
    output rsp_pkg::t_job                    o_job
);

    logic [rsp_pkg::NUM_WORDS-1:0][rsp_pkg::WORD_W-1:0] r_words;
    logic accept;
    logic is_radius;

    assign accept    = i_valid && !i_full;
    assign is_radius = (i_word_index == rsp_pkg::RADIUS_IDX);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_words[i_word_index] <= i_word_value;
        end
    end

    always_comb begin
        o_job.words               = r_words;
        o_job.words[i_word_index] = i_word_value;
        o_job.tag                 = i_instance_tag;
        o_job.eval                = is_radius;
        o_job.report              = i_frame_end;
        o_push                    = accept && (is_radius || i_frame_end) && i_rst_n;
    end

endmodule
`default_nettype wire

// ===== rtl/core/rsp_queue.sv =====
// short job queue between front end and back end
`default_nettype none
module rsp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rsp_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic               o_full,
    output rsp_pkg::t_job      o_job
);

    localparam int QW = (rsp_pkg::QUEUE_DEPTH > 1) ? $clog2(rsp_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(rsp_pkg::QUEUE_DEPTH + 1);

    rsp_pkg::t_job r_mem [rsp_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wp;
    logic [QW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(rsp_pkg::QUEUE_DEPTH));
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QW'(rsp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QW'(rsp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rsp_isqrt.sv =====
// iterative integer square root, one result bit per cycle
`default_nettype none
module rsp_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic [63:0] r_x;
    logic [35:0] r_rem;
    logic [31:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        take;

    assign rem2  = {r_rem[33:0], r_x[63:62]};
    assign trial = {2'b00, r_q, 2'b01};
    assign take  = (rem2 >= trial);

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[61:0], 2'b00};
            r_rem <= take ? rem2 - trial : rem2;
            r_q   <= {r_q[30:0], take};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rsp_back.sv =====
// back end: sphere transform, ray test, nearest list and frame report
`default_nettype none
module rsp_back #(
    parameter int KEEP_NEAREST = rsp_pkg::KEEP_NEAREST_DEF,
    parameter int TAG_BITS     = rsp_pkg::TAG_BITS_DEF,
    parameter int COUNT_BITS   = rsp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_job_valid,
    input  wire rsp_pkg::t_job            i_job,
    output logic                          o_job_pop,
    input  wire logic signed [31:0]       i_eye_x,
    input  wire logic signed [31:0]       i_eye_y,
    input  wire logic signed [31:0]       i_eye_z,
    input  wire logic signed [17:0]       i_dir_x,
    input  wire logic signed [17:0]       i_dir_y,
    input  wire logic signed [17:0]       i_dir_z,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_is_summary,
    output logic [15:0]                   o_hit_total,
    output logic [2:0]                    o_rank,
    output logic [30:0]                   o_entry_distance,
    output logic [30:0]                   o_world_radius,
    output logic [15:0]                   o_hit_tag,
    output logic                          o_last_result
);

    localparam int IW = (KEEP_NEAREST > 1) ? $clog2(KEEP_NEAREST) : 1;
    localparam int KW = $clog2(KEEP_NEAREST + 1);

    function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
        if (v > 54'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -54'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [32:0] s33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    rsp_pkg::t_state r_state, n_state;
    rsp_pkg::t_job   r_job;

    logic [1:0] r_k, r_pk;
    logic [2:0] r_j, r_pj;
    logic       r_pv;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod;

    logic signed [51:0] r_c;
    logic signed [31:0] r_to [3];
    logic [63:0]        r_col;
    logic signed [51:0] r_along;
    logic [63:0]        r_tt;
    logic signed [31:0] r_alg;
    logic [30:0]        r_len;
    logic [30:0]        r_r;
    logic [63:0]        r_a2;
    logic [30:0]        r_dist;

    logic [30:0]         r_nd [KEEP_NEAREST];
    logic [30:0]         r_nr [KEEP_NEAREST];
    logic [TAG_BITS-1:0] r_nt [KEEP_NEAREST];
    logic [KW-1:0]       r_kept;
    logic [COUNT_BITS-1:0] r_hits;

    logic [2:0] r_ri;
    logic [3:0] r_n;

    logic        sq_start, sq_busy, sq_done;
    logic [63:0] sq_x;
    logic [31:0] sq_root;

    logic        out_free;
    logic        load_sum, load_hit, report_end;
    logic [3:0]  n_cnt;

    logic signed [51:0] acc_c;
    logic signed [31:0] c32;
    logic signed [31:0] eye_sel;
    logic signed [33:0] tdiff;
    logic [64:0]        sum65;
    logic signed [33:0] reach;
    logic               miss;
    logic signed [33:0] dd;
    logic [3:0]         widx;
    logic [KEEP_NEAREST-1:0] le;

    rsp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign out_free = !o_valid || !i_stall;
    assign n_cnt    = (int'(r_kept) > rsp_pkg::REPORT_MAX) ? 4'(rsp_pkg::REPORT_MAX)
                                                           : 4'(r_kept);

    // ray test terms
    assign sum65 = {1'b0, r_a2} + {1'b0, r_prod[63:0]};
    assign reach = 34'(r_alg) + $signed({3'b000, r_r});
    assign miss  = ({1'b0, r_tt} > sum65) || (reach < 0);
    assign dd    = 34'(r_alg) - $signed({2'b00, sq_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        sq_start   = 1'b0;
        sq_x       = r_col;
        load_sum   = 1'b0;
        load_hit   = 1'b0;
        report_end = 1'b0;
        case (r_state)
            rsp_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    if (i_job.eval && !i_job.words[rsp_pkg::RADIUS_IDX][31]) begin
                        n_state = rsp_pkg::S_MUL;
                    end else if (i_job.report) begin
                        n_state = rsp_pkg::S_SUM;
                    end
                end
            end
            rsp_pkg::S_MUL: begin
                if (r_k == 2'd2 && r_j == 3'd5) begin
                    n_state = rsp_pkg::S_DRAIN;
                end
            end
            rsp_pkg::S_DRAIN: n_state = rsp_pkg::S_SQ1;
            rsp_pkg::S_SQ1: begin
                sq_start = 1'b1;
                n_state  = rsp_pkg::S_SQ1W;
            end
            rsp_pkg::S_SQ1W: begin
                if (sq_done) begin
                    n_state = rsp_pkg::S_RAD;
                end
            end
            rsp_pkg::S_RAD:  n_state = rsp_pkg::S_RSAT;
            rsp_pkg::S_RSAT: n_state = rsp_pkg::S_RSQ;
            rsp_pkg::S_RSQ:  n_state = rsp_pkg::S_TEST;
            rsp_pkg::S_TEST: begin
                if (miss) begin
                    n_state = r_job.report ? rsp_pkg::S_SUM : rsp_pkg::S_IDLE;
                end else begin
                    sq_start = 1'b1;
                    sq_x     = sum65[63:0] - r_tt;
                    n_state  = rsp_pkg::S_SQ2W;
                end
            end
            rsp_pkg::S_SQ2W: begin
                if (sq_done) begin
                    n_state = rsp_pkg::S_INS;
                end
            end
            rsp_pkg::S_INS: n_state = r_job.report ? rsp_pkg::S_SUM : rsp_pkg::S_IDLE;
            rsp_pkg::S_SUM: begin
                if (out_free) begin
                    load_sum = 1'b1;
                    if (n_cnt == 4'd0) begin
                        report_end = 1'b1;
                        n_state    = rsp_pkg::S_IDLE;
                    end else begin
                        n_state = rsp_pkg::S_HITS;
                    end
                end
            end
            rsp_pkg::S_HITS: begin
                if (out_free) begin
                    load_hit = 1'b1;
                    if ({1'b0, r_ri} == r_n - 4'd1) begin
                        report_end = 1'b1;
                        n_state    = rsp_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = rsp_pkg::S_IDLE;
        endcase
    end

    // shared multiplier operand select
    assign widx = {r_j[1:0], 1'b0} + {2'b00, r_j[1:0]} + {2'b00, r_k};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            rsp_pkg::S_MUL: begin
                case (r_j)
                    3'd0, 3'd1, 3'd2: begin
                        mul_a = s33(r_job.words[widx]);
                        mul_b = s33(r_job.words[rsp_pkg::CENTER_IDX + 4'(r_j)]);
                    end
                    3'd3: begin
                        mul_a = s33(r_job.words[4'(r_k)]);
                        mul_b = s33(r_job.words[4'(r_k)]);
                    end
                    3'd4: begin
                        mul_a = 33'(r_to[r_k]);
                        case (r_k)
                            2'd0:    mul_b = 33'(i_dir_x);
                            2'd1:    mul_b = 33'(i_dir_y);
                            default: mul_b = 33'(i_dir_z);
                        endcase
                    end
                    default: begin
                        mul_a = 33'(r_to[r_k]);
                        mul_b = 33'(r_to[r_k]);
                    end
                endcase
            end
            rsp_pkg::S_RAD: begin
                mul_a = $signed({2'b00, r_job.words[rsp_pkg::RADIUS_IDX][30:0]});
                mul_b = $signed({2'b00, r_len});
            end
            rsp_pkg::S_RSAT: begin
                mul_a = 33'(r_alg);
                mul_b = 33'(r_alg);
            end
            rsp_pkg::S_RSQ: begin
                mul_a = $signed({2'b00, r_r});
                mul_b = $signed({2'b00, r_r});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulation of the registered product
    always_comb begin
        acc_c = ((r_pj == 3'd0) ? 52'($signed(r_job.words[rsp_pkg::TRANS_IDX + 4'(r_pk)]))
                                : r_c) + 52'(r_prod >>> 16);
        c32   = sat32(54'(acc_c));
        case (r_pk)
            2'd0:    eye_sel = i_eye_x;
            2'd1:    eye_sel = i_eye_y;
            default: eye_sel = i_eye_z;
        endcase
        tdiff = 34'(c32) - 34'(eye_sel);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_pk   <= r_k;
        r_pj   <= r_j;
        if (o_job_pop) begin
            r_job   <= i_job;
            r_k     <= '0;
            r_j     <= '0;
            r_c     <= '0;
            r_col   <= '0;
            r_along <= '0;
            r_tt    <= '0;
        end else begin
            if (r_state == rsp_pkg::S_MUL) begin
                if (r_j == 3'd5) begin
                    r_j <= '0;
                    r_k <= r_k + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_pv) begin
                case (r_pj)
                    3'd0, 3'd1: r_c <= acc_c;
                    3'd2:       r_to[r_pk] <= sat32(54'(tdiff));
                    3'd3:       r_col <= r_col + r_prod[63:0];
                    3'd4:       r_along <= r_along + 52'(r_prod);
                    default:    r_tt <= r_tt + r_prod[63:0];
                endcase
            end
        end
        case (r_state)
            rsp_pkg::S_SQ1: r_alg <= sat32(54'(r_along >>> 16));
            rsp_pkg::S_SQ1W: begin
                r_len <= sq_root[31] ? rsp_pkg::U31_MAX : sq_root[30:0];
            end
            rsp_pkg::S_RSAT: begin
                r_r <= (r_prod[65:47] != '0) ? rsp_pkg::U31_MAX : r_prod[46:16];
            end
            rsp_pkg::S_RSQ: r_a2 <= r_prod[63:0];
            rsp_pkg::S_SQ2W: begin
                if (dd < 0) begin
                    r_dist <= '0;
                end else if (dd > 34'sd2147483647) begin
                    r_dist <= rsp_pkg::U31_MAX;
                end else begin
                    r_dist <= dd[30:0];
                end
            end
            default: r_dist <= r_dist;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == rsp_pkg::S_MUL);
        end
    end

    // ordered insertion into the nearest list
    always_comb begin
        for (int i = 0; i < KEEP_NEAREST; i++) begin
            le[i] = (i < int'(r_kept)) && (r_nd[i] <= r_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rsp_pkg::S_INS) begin
            for (int i = 0; i < KEEP_NEAREST; i++) begin
                if (!le[i]) begin
                    if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                        r_nd[i] <= r_dist;
                        r_nr[i] <= r_r;
                        r_nt[i] <= TAG_BITS'(r_job.tag);
                    end else begin
                        r_nd[i] <= r_nd[(i == 0) ? 0 : i - 1];
                        r_nr[i] <= r_nr[(i == 0) ? 0 : i - 1];
                        r_nt[i] <= r_nt[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
            r_hits <= '0;
        end else if (report_end) begin
            r_kept <= '0;
            r_hits <= '0;
        end else if (r_state == rsp_pkg::S_INS) begin
            if (r_hits != '1) begin
                r_hits <= r_hits + 1'b1;
            end
            if (int'(r_kept) < KEEP_NEAREST) begin
                r_kept <= r_kept + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_ri    <= '0;
            r_n     <= '0;
        end else begin
            if (load_sum || load_hit) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            if (load_sum) begin
                r_n  <= n_cnt;
                r_ri <= '0;
            end else if (load_hit) begin
                r_ri <= r_ri + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_sum) begin
            o_is_summary     <= 1'b1;
            o_hit_total      <= 16'(r_hits);
            o_rank           <= '0;
            o_entry_distance <= '0;
            o_world_radius   <= '0;
            o_hit_tag        <= '0;
            o_last_result    <= (n_cnt == 4'd0);
        end else if (load_hit) begin
            o_is_summary     <= 1'b0;
            o_hit_total      <= '0;
            o_rank           <= r_ri;
            o_entry_distance <= r_nd[IW'(r_ri)];
            o_world_radius   <= r_nr[IW'(r_ri)];
            o_hit_tag        <= 16'(r_nt[IW'(r_ri)]);
            o_last_result    <= ({1'b0, r_ri} == r_n - 4'd1);
        end
    end

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_kept) <= KEEP_NEAREST)
        else $error("nearest list count above capacity");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root started while busy");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsp_pkg::S_HITS) |-> ({1'b0, r_ri} < r_n))
        else $error("report index beyond kept hits");

    a_report_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        report_end |=> (r_kept == '0) && (r_hits == '0))
        else $error("hit state not cleared after report");

endmodule
`default_nettype wire

// ===== rtl/core/ray_sphere_pick_nearest_core.sv =====
// top level: configuration registers, front end, job queue and back end
// words are taken one per cycle until the two-entry job queue fills;
// the back end works on one job at a time and pops the next job only from idle
// a frame report emits a summary result and then up to 8 hit results
// reset is synchronous active low and clears control state and configuration,
// except that the direction z register resets to 65536
`default_nettype none
module ray_sphere_pick_nearest_core #(
    parameter int KEEP_NEAREST = rsp_pkg::KEEP_NEAREST_DEF,
    parameter int TAG_BITS     = rsp_pkg::TAG_BITS_DEF,
    parameter int COUNT_BITS   = rsp_pkg::COUNT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_word_value,
    input  wire logic [3:0]         i_word_index,
    input  wire logic [15:0]        i_instance_tag,
    input  wire logic               i_frame_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_is_summary,
    output logic [15:0]             o_hit_total,
    output logic [2:0]              o_rank,
    output logic [30:0]             o_entry_distance,
    output logic [30:0]             o_world_radius,
    output logic [15:0]             o_hit_tag,
    output logic                    o_last_result
);

    logic signed [31:0] r_eye_x, r_eye_y, r_eye_z;
    logic signed [17:0] r_dir_x, r_dir_y, r_dir_z;

    logic          q_full, q_valid, q_pop, f_push;
    rsp_pkg::t_job f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x <= '0;
            r_eye_y <= '0;
            r_eye_z <= '0;
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= rsp_pkg::DIR_Z_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rsp_pkg::CFG_EYE_X: r_eye_x <= i_cfg_data;
                rsp_pkg::CFG_EYE_Y: r_eye_y <= i_cfg_data;
                rsp_pkg::CFG_EYE_Z: r_eye_z <= i_cfg_data;
                rsp_pkg::CFG_DIR_X: r_dir_x <= i_cfg_data[17:0];
                rsp_pkg::CFG_DIR_Y: r_dir_y <= i_cfg_data[17:0];
                rsp_pkg::CFG_DIR_Z: r_dir_z <= i_cfg_data[17:0];
                default: r_eye_x <= r_eye_x;
            endcase
        end
    end

    assign o_in_stall = q_full;

    rsp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_full         (q_full),
        .i_word_value   (i_word_value),
        .i_word_index   (i_word_index),
        .i_instance_tag (i_instance_tag),
        .i_frame_end    (i_frame_end),
        .o_push         (f_push),
        .o_job          (f_job)
    );

    rsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    rsp_back #(
        .KEEP_NEAREST (KEEP_NEAREST),
        .TAG_BITS     (TAG_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (q_valid),
        .i_job            (q_job),
        .o_job_pop        (q_pop),
        .i_eye_x          (r_eye_x),
        .i_eye_y          (r_eye_y),
        .i_eye_z          (r_eye_z),
        .i_dir_x          (r_dir_x),
        .i_dir_y          (r_dir_y),
        .i_dir_z          (r_dir_z),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_is_summary     (o_is_summary),
        .o_hit_total      (o_hit_total),
        .o_rank           (o_rank),
        .o_entry_distance (o_entry_distance),
        .o_world_radius   (o_world_radius),
        .o_hit_tag        (o_hit_tag),
        .o_last_result    (o_last_result)
    );

endmodule
`default_nettype wire
